### hw/rtl/jse_pkg.sv
`timescale 1ns / 1ps
// jse_pkg: shared types, character codes and helpers for the JSON string escaper.
// No dependencies; every other file of the block refers to it by scoped names.
package jse_pkg;

   localparam int CharWidth  = 21;
   localparam int EscWidth   = 16;
   localparam int CountWidth = 4;   // up to 14 output words per input word
   localparam int QueueDepth = 2;

   localparam logic [CharWidth-1:0] CharQuote     = 21'h22;
   localparam logic [CharWidth-1:0] CharBackslash = 21'h5C;
   localparam logic [CharWidth-1:0] CharLowerU    = 21'h75;

   localparam logic [CharWidth-1:0] AsciiLast   = 21'h7E;
   localparam logic [CharWidth-1:0] ControlLast = 21'h1F;
   localparam logic [CharWidth-1:0] BmpLast     = 21'hFFFF;
   localparam logic [CharWidth-1:0] SuppBase    = 21'h10000;
   localparam logic [EscWidth-1:0]  HighSurr    = 16'hD800;
   localparam logic [EscWidth-1:0]  LowSurr     = 16'hDC00;
   localparam logic [9:0]           SurrMask    = 10'h3FF;

   typedef enum logic [2:0] {
      KindNone  = 3'd0,   // no character, quotes only
      KindPlain = 3'd1,   // character passes through
      KindShort = 3'd2,   // backslash plus one letter
      KindEsc1  = 3'd3,   // one \uXXXX
      KindEsc2  = 3'd4    // surrogate pair, two \uXXXX
   } jse_kind_type;

   typedef struct packed {
      logic [CharWidth-1:0] code_point;
      logic                 has_char;
      logic                 string_start;
      logic                 string_end;
   } jse_req_type;

   typedef struct packed {
      logic [CharWidth-1:0] out_char;
      logic                 last_of_run;
   } jse_rsp_type;

   // Classified job handed from the front to the back.
   typedef struct packed {
      logic                  start_quote;
      jse_kind_type          kind;
      logic [CountWidth-1:0] total_len;
      logic [CharWidth-1:0]  body_char;   // plain char or short-escape letter
      logic [EscWidth-1:0]   esc_hi;
      logic [EscWidth-1:0]   esc_lo;
   } jse_job_type;

   function automatic logic [CharWidth-1:0] hex_digit(input logic [3:0] nib);
      logic [CharWidth-1:0] ch;
      if (nib < 4'd10) begin
         ch = 21'h30 + CharWidth'(nib);
      end else begin
         ch = 21'h57 + CharWidth'(nib);   // 'a' - 10
      end
      return ch;
   endfunction

   function automatic logic [CountWidth-1:0] body_len(input jse_kind_type kind);
      logic [CountWidth-1:0] len;
      case (kind)
         KindPlain: len = 4'd1;
         KindShort: len = 4'd2;
         KindEsc1:  len = 4'd6;
         KindEsc2:  len = 4'd12;
         default:   len = 4'd0;
      endcase
      return len;
   endfunction

endpackage

### hw/rtl/jse_front.sv
`timescale 1ns / 1ps
// jse_front: holds the wide-char escape register and classifies each request word into a job.
// Depends on jse_pkg.
module jse_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_word,
   input  jse_pkg::jse_req_type req_word,
   output jse_pkg::jse_job_type job,
   output logic                job_empty
);

   logic esc_wide_ff, esc_wide_in;

   logic [jse_pkg::CharWidth-1:0] cp;
   logic [jse_pkg::CharWidth-1:0] reduced;
   logic [jse_pkg::CharWidth-1:0] short_ch;
   logic [jse_pkg::CountWidth-1:0] len;

   assign csr_ready   = 1'b1;
   assign esc_wide_in = csr_valid ? csr_word : esc_wide_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_wide_ff <= 1'b1;
      end else begin
         esc_wide_ff <= esc_wide_in;
      end
   end

   always_comb begin
      cp      = req_word.code_point;
      reduced = cp - jse_pkg::SuppBase;
      case (cp)
         21'h08:  short_ch = 21'h62;   // b
         21'h09:  short_ch = 21'h74;   // t
         21'h0A:  short_ch = 21'h6E;   // n
         21'h0C:  short_ch = 21'h66;   // f
         21'h0D:  short_ch = 21'h72;   // r
         21'h22:  short_ch = 21'h22;
         21'h2F:  short_ch = 21'h2F;
         21'h5C:  short_ch = 21'h5C;
         default: short_ch = '0;
      endcase

      job.start_quote = req_word.string_start;
      job.body_char   = cp;
      job.esc_hi      = cp[jse_pkg::EscWidth-1:0];
      job.esc_lo      = '0;
      if (!req_word.has_char) begin
         job.kind = jse_pkg::KindNone;
      end else if (short_ch != '0) begin
         job.kind      = jse_pkg::KindShort;
         job.body_char = short_ch;
      end else if (cp <= jse_pkg::ControlLast) begin
         job.kind = jse_pkg::KindEsc1;
      end else if (esc_wide_ff && (cp > jse_pkg::BmpLast)) begin
         // surrogate pair; only the low 16 bits of each half are shown
         job.kind   = jse_pkg::KindEsc2;
         job.esc_hi = jse_pkg::EscWidth'(reduced[jse_pkg::CharWidth-1:10]) + jse_pkg::HighSurr;
         job.esc_lo = {6'd0, reduced[9:0] & jse_pkg::SurrMask} + jse_pkg::LowSurr;
      end else if (esc_wide_ff && (cp > jse_pkg::AsciiLast)) begin
         job.kind = jse_pkg::KindEsc1;
      end else begin
         job.kind = jse_pkg::KindPlain;
      end

      len = jse_pkg::body_len(job.kind)
            + jse_pkg::CountWidth'(req_word.string_start)
            + jse_pkg::CountWidth'(req_word.string_end);
      job.total_len = len;
      job_empty     = (len == '0);
   end

endmodule

### hw/rtl/jse_queue.sv
`timescale 1ns / 1ps
// jse_queue: small register FIFO of classified jobs between front and back.
// Depends on jse_pkg.
module jse_queue #(
   parameter int Depth = jse_pkg::QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  jse_pkg::jse_job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output jse_pkg::jse_job_type head_job
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   jse_pkg::jse_job_type slot_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] p);
      logic [PtrWidth-1:0] n;
      if (p == PtrWidth'(Depth - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   assign full       = (count_ff == CntWidth'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### hw/rtl/jse_back.sv
`timescale 1ns / 1ps
// jse_back: walks head job into response register, one char per cycle unless stalled.
// Depends on jse_pkg.
module jse_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  jse_pkg::jse_job_type head_job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output jse_pkg::jse_rsp_type rsp_word
);

   logic [jse_pkg::CountWidth-1:0] pos_ff, pos_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   jse_pkg::jse_rsp_type           rsp_word_ff, rsp_word_in;

   logic                           load;
   logic                           last;
   logic [jse_pkg::CountWidth-1:0] b;
   logic [jse_pkg::CountWidth-1:0] j_full;
   logic [2:0]                     j;
   logic [jse_pkg::EscWidth-1:0]   v;
   logic [jse_pkg::CharWidth-1:0]  ch;

   always_comb begin
      b = pos_ff - jse_pkg::CountWidth'(head_job.start_quote);
      if (b < 4'd6) begin
         j_full = b;
         v      = head_job.esc_hi;
      end else begin
         j_full = b - 4'd6;
         v      = head_job.esc_lo;
      end
      j = j_full[2:0];

      if (head_job.start_quote && (pos_ff == '0)) begin
         ch = jse_pkg::CharQuote;
      end else if (b < jse_pkg::body_len(head_job.kind)) begin
         case (head_job.kind)
            jse_pkg::KindPlain: ch = head_job.body_char;
            jse_pkg::KindShort: ch = (b == '0) ? jse_pkg::CharBackslash : head_job.body_char;
            jse_pkg::KindEsc1, jse_pkg::KindEsc2: begin
               case (j)
                  3'd0:    ch = jse_pkg::CharBackslash;
                  3'd1:    ch = jse_pkg::CharLowerU;
                  3'd2:    ch = jse_pkg::hex_digit(v[15:12]);
                  3'd3:    ch = jse_pkg::hex_digit(v[11:8]);
                  3'd4:    ch = jse_pkg::hex_digit(v[7:4]);
                  default: ch = jse_pkg::hex_digit(v[3:0]);
               endcase
            end
            default: ch = jse_pkg::CharQuote;
         endcase
      end else begin
         ch = jse_pkg::CharQuote;
      end

      last = (pos_ff == head_job.total_len - 1'b1);
      load = head_valid && (!rsp_valid_ff || rsp_ready);
      pop  = load && last;

      pos_in = pos_ff;
      if (load) begin
         pos_in = last ? '0 : pos_ff + 1'b1;
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
      rsp_word_in  = rsp_word_ff;
      if (load) begin
         rsp_word_in.out_char    = ch;
         rsp_word_in.last_of_run = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### hw/rtl/json_string_escaper_core.sv
`timescale 1ns / 1ps
// JSON string escaper: one code point per request word, one output char per response word.
// Accepted words are written to the queue, then their characters to the response register.
// Throughput: 1 response word per cycle unless rsp_ready stalls, set by the back end's
//   single output register; an item of N words (1..14) holds the back end until its last word.
// Reset (synchronous, active high): queue and response register empty, wide escaping on.
// Depends on jse_pkg, jse_front, jse_queue, jse_back.
module json_string_escaper_core #(
   parameter int QueueDepth = jse_pkg::QueueDepth   // jobs buffered between front and back, >= 2
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel: one code point plus string framing flags
   input  logic                 req_valid,
   output logic                 req_ready,
   input  jse_pkg::jse_req_type req_word,
   // response channel: one output character per word
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output jse_pkg::jse_rsp_type rsp_word,
   // configuration: wide-char escape register
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_word
);

   jse_pkg::jse_job_type front_job;
   jse_pkg::jse_job_type head_job;
   logic                 front_empty;
   logic                 q_full;
   logic                 q_push;
   logic                 q_pop;
   logic                 head_valid;

   // Front end: register plus classification of the incoming word into a job.
   jse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_word  (csr_word),
      .req_word  (req_word),
      .job       (front_job),
      .job_empty (front_empty)
   );

   // Words that produce nothing are accepted and dropped here.
   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready && !front_empty;

   jse_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (front_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Back end: sequence the head job's characters into the response register.
   jse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule
